>>> hdl/odq_pkg.sv
// shared types and codes for the ordered deque with value removal
package odq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  // the command that every cell carries out
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INS_FRONT,
    CMD_WR_AT,
    CMD_PULL,
    CMD_ROT
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    word_t     value;
    word_t     head;
  } cell_bus_t;

endpackage

>>> hdl/ordered_deque_with_value_removal.sv
// top level: cell chain of the ordered deque plus its sequencer
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  command  | start_i, busy_o         | op_i, value_i
//  result   | valid_o (one cycle)     | removed_value_o, status_o, occupancy_o
//
// push front, push back, pop front and every rejected or unknown op do not
// enter the sweep; the result shows in the cycle after the transfer.
// pop back and remove sweep the live entries once through cell 0 by rotating
// the chain while busy_o is high.
// reset clears the count and control only; cell contents stay undefined.
// results cannot be stalled; a new command is taken while a result is shown.
module ordered_deque_with_value_removal #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [odq_pkg::OP_W-1:0]    op_i,
  input  odq_pkg::word_t              value_i,
  output logic                        valid_o,
  output odq_pkg::word_t              removed_value_o,
  output logic [odq_pkg::STAT_W-1:0]  status_o,
  output logic [odq_pkg::OCC_W-1:0]   occupancy_o
);
  import odq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  logic              state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     step_q, step_d;
  logic [CW-1:0]     orig_q, orig_d;
  logic              hit_q, hit_d;
  logic              popb_q, popb_d;
  word_t             key_q, key_d;
  word_t             rem_q, rem_d;

  logic              valid_q, valid_d;
  word_t             res_val_q, res_val_d;
  logic [STAT_W-1:0] res_st_q, res_st_d;
  logic [OCC_W-1:0]  res_occ_q;

  cell_bus_t         bus;
  cell_cmd_e         bus_cmd;
  word_t             cell_data [DEPTH];
  logic              take;
  logic              last_step;

  assign bus = '{cmd: bus_cmd, value: value_i, head: cell_data[0]};

  assign last_step = (step_q == orig_q - CNT_ONE);
  assign take      = popb_q ? last_step : (!hit_q && (cell_data[0] == key_q));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    orig_d    = orig_q;
    hit_d     = hit_q;
    popb_d    = popb_q;
    key_d     = key_q;
    rem_d     = rem_q;
    valid_d   = 1'b0;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    bus_cmd   = CMD_HOLD;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          valid_d   = 1'b1;
          res_val_d = '0;
          res_st_d  = STAT_OK;
          case (op_i)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (cnt_q == CNT_FULL) begin
                res_st_d = STAT_FULL;
              end else begin
                bus_cmd = (op_i == OP_PUSH_FRONT) ? CMD_INS_FRONT : CMD_WR_AT;
                cnt_d   = cnt_q + CNT_ONE;
              end
            end
            OP_POP_FRONT: begin
              if (cnt_q == '0) begin
                res_st_d = STAT_EMPTY;
              end else begin
                bus_cmd   = CMD_PULL;
                res_val_d = cell_data[0];
                cnt_d     = cnt_q - CNT_ONE;
              end
            end
            OP_POP_BACK, OP_REMOVE: begin
              if (cnt_q == '0) begin
                res_st_d = STAT_EMPTY;
              end else begin
                // result comes at the end of the sweep
                valid_d = 1'b0;
                state_d = S_SCAN;
                step_d  = '0;
                orig_d  = cnt_q;
                hit_d   = 1'b0;
                popb_d  = (op_i == OP_POP_BACK);
                key_d   = value_i;
              end
            end
            default: begin
              res_st_d = STAT_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        step_d = step_q + CNT_ONE;
        if (take) begin
          bus_cmd = CMD_PULL;
          cnt_d   = cnt_q - CNT_ONE;
          hit_d   = 1'b1;
          rem_d   = cell_data[0];
        end else begin
          bus_cmd = CMD_ROT;
        end
        if (last_step) begin
          state_d   = S_IDLE;
          valid_d   = 1'b1;
          res_val_d = take ? cell_data[0] : (hit_q ? rem_q : '0);
          res_st_d  = (take || hit_q) ? STAT_OK : STAT_NOTFOUND;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      orig_q  <= '0;
      hit_q   <= 1'b0;
      popb_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      orig_q  <= orig_d;
      hit_q   <= hit_d;
      popb_q  <= popb_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    rem_q     <= rem_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    res_occ_q <= OCC_W'(cnt_d);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    odq_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .bus_i   (bus),
      .cnt_i   (cnt_q),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g])
    );
  end

  assign busy_o          = (state_q == S_SCAN);
  assign valid_o         = valid_q;
  assign removed_value_o = res_val_q;
  assign status_o        = res_st_q;
  assign occupancy_o     = res_occ_q;

`ifndef SYNTHESIS
  a_cnt_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("entry count above depth");

  a_scan_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cnt_q != '0 && step_q < orig_q)
    else $error("sweep running past live entries");

  a_full_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == STAT_FULL |-> cnt_q == CNT_FULL)
    else $error("full reported while not full");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == STAT_EMPTY |-> cnt_q == '0)
    else $error("empty reported while entries held");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != STAT_OK |-> removed_value_o == '0)
    else $error("failed transfer returned a word");
`endif

endmodule

>>> hdl/odq_cell.sv
// one storage cell of the deque chain
module odq_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  odq_pkg::cell_bus_t bus_i,
  input  logic [CW-1:0]     cnt_i,
  input  odq_pkg::word_t    left_i,
  input  odq_pkg::word_t    right_i,
  output odq_pkg::word_t    data_o
);
  import odq_pkg::*;

  localparam logic [CW-1:0] POS      = CW'(IDX);
  localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

  word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (bus_i.cmd)
      CMD_INS_FRONT: begin
        data_d = left_i;
      end
      CMD_WR_AT: begin
        if (cnt_i == POS) begin
          data_d = bus_i.value;
        end
      end
      CMD_PULL: begin
        if (POS_NEXT < cnt_i) begin
          data_d = right_i;
        end
      end
      CMD_ROT: begin
        // ring of cnt entries: the last live cell takes the old head
        if (POS_NEXT < cnt_i) begin
          data_d = right_i;
        end else if (POS_NEXT == cnt_i) begin
          data_d = bus_i.head;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
